FILE: sv/mfud_pkg.sv
package mfud_pkg;

  // shared multiplier: signed operands wide enough for a 32-bit unsigned scale
  localparam int unsigned MUL_W   = 33;
  localparam int unsigned PROD_W  = 2 * MUL_W;

  // unwrapped count fits raw + (32-bit turns) * (2 * 15-bit half turn)
  localparam int unsigned COUNT_W = 49;
  localparam int unsigned LO_W    = 24;
  localparam int unsigned HI_W    = COUNT_W - LO_W;

  // fixed-point result widths
  localparam int unsigned FRAC_SH = 12;
  localparam int unsigned POS_W   = 48;
  localparam int unsigned VEL_W   = 32;
  localparam int unsigned ACC_W   = COUNT_W + 32;

  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // configuration port
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_ID    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HALF_TURN      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_POSITION_SCALE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VELOCITY_SCALE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TORQUE_SCALE   = 3'd4;

  localparam logic [10:0] RST_FEEDBACK_ID    = 11'd0;
  localparam logic [14:0] RST_HALF_TURN      = 15'd16384;
  localparam logic [31:0] RST_POSITION_SCALE = 32'd102400;
  localparam logic [31:0] RST_VELOCITY_SCALE = 32'd3932160;
  localparam logic [31:0] RST_TORQUE_SCALE   = 32'd1310720;

  typedef struct packed {
    logic [10:0] feedback_id;
    logic [14:0] half_turn_counts;
    logic [31:0] position_scale;
    logic [31:0] velocity_scale;
    logic [31:0] torque_scale;
  } cfg_t;

endpackage

FILE: sv/motor_feedback_unwrap_decoder.sv
// Decoder for 8-byte motor feedback frames arriving over a stream port, one
// frame per request with its 11-bit identifier in tuser. A frame whose
// identifier differs from feedback_id is taken and gives no
// result. A matching frame updates the multi-turn state (last raw position
// and a TURN_BITS-wide turn counter, stepped by the wrapped 16-bit delta
// against half_turn_counts) in the cycle it is taken, then keeps the input
// side busy for five passes through one shared, registered
// 33x33 signed multiplier (turns times a full turn, velocity against its
// scale, the unwrapped count in two partial products against
// position_scale, then torque against its scale) and a final state that
// loads the result register. That state stretches while an earlier result
// is still waiting downstream. So the input side takes no new frame until
// a matching frame's result has been loaded.
// Position comes out as Q31.16 saturated to 48 bits, velocity and torque as
// Q15.16, all with floor truncation. Registers sit on an APB-style port at
// byte addresses 0, 4, 8, 12 and 16; the user must write them only while
// the block is idle, which the block itself does not enforce.
module motor_feedback_unwrap_decoder #(
  parameter int unsigned TURN_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // byte_0 [7:0], byte_1 [15:8], ... byte_7 [63:56]
  input  logic [63:0]                     s_axis_tdata,
  // frame_id [10:0]
  input  logic [10:0]                     s_axis_tuser,
  // stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // position_q16 [47:0], velocity_q16 [79:48], torque_q16 [111:80],
  // fault_code [115:112], motor_index [119:116], stage_temp [127:120],
  // rotor_temp [135:128]
  output logic [135:0]                    m_axis_tdata,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mfud_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mfud_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mfud_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mfud_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TURN  = 3'd1;
  localparam logic [2:0] S_COUNT = 3'd2;
  localparam logic [2:0] S_LO    = 3'd3;
  localparam logic [2:0] S_HI    = 3'd4;
  localparam logic [2:0] S_TRQ   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  cfg_t cfg;

  logic [2:0] state_q, state_d;

  // multi-turn state
  logic [15:0]          last_q, last_d;
  logic [TURN_BITS-1:0] turn_q, turn_d;

  // captured frame fields
  logic signed [15:0] raw_pos_q;
  logic signed [11:0] raw_vel_q;
  logic signed [11:0] raw_trq_q;
  logic [7:0]         byte0_q, stage_q, rotor_q;

  // working registers
  logic signed [COUNT_W-1:0] count_q, count_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [VEL_W-1:0]          vel_q, vel_d;

  // result register
  logic         out_valid_q, out_valid_d;
  logic [135:0] out_data_q, out_data_d;

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;

  logic                 in_fire, id_match, load_out;
  logic [15:0]          pos_bits, diff;
  logic signed [16:0]   delta, half;
  logic [POS_W-1:0]     pos_sat;
  logic [VEL_W-1:0]     trq_res;
  logic [ACC_W-POS_W-FRAC_SH:0] acc_top;

  mfud_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mfud_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign id_match      = (s_axis_tuser == cfg.feedback_id);

  // wrap detection on the incoming raw position
  assign pos_bits = {s_axis_tdata[15:8], s_axis_tdata[23:16]};
  assign diff     = pos_bits - last_q;
  assign delta    = 17'(signed'(diff));
  assign half     = signed'({2'b00, cfg.half_turn_counts});

  always_comb begin
    last_d = last_q;
    turn_d = turn_q;
    if (in_fire && id_match) begin
      last_d = pos_bits;
      if (delta > half) begin
        turn_d = turn_q - TURN_BITS'(1);
      end else if (delta < -half) begin
        turn_d = turn_q + TURN_BITS'(1);
      end
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      S_TURN: begin
        op_a = MUL_W'(signed'(turn_q));
        op_b = MUL_W'({cfg.half_turn_counts, 1'b0});
      end
      S_COUNT: begin
        op_a = MUL_W'(raw_vel_q);
        op_b = MUL_W'(cfg.velocity_scale);
      end
      S_LO: begin
        op_a = MUL_W'(count_q[LO_W-1:0]);
        op_b = MUL_W'(cfg.position_scale);
      end
      S_HI: begin
        op_a = MUL_W'(signed'(count_q[COUNT_W-1:LO_W]));
        op_b = MUL_W'(cfg.position_scale);
      end
      S_TRQ: begin
        op_a = MUL_W'(raw_trq_q);
        op_b = MUL_W'(cfg.torque_scale);
      end
      S_DONE: begin
        // keep the torque product in place while the result waits
        op_a = MUL_W'(raw_trq_q);
        op_b = MUL_W'(cfg.torque_scale);
      end
      default: ;
    endcase
  end

  // saturate the floored position to 48 bits
  assign acc_top = acc_q[ACC_W-1:POS_W+FRAC_SH-1];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      pos_sat = acc_q[POS_W+FRAC_SH-1:FRAC_SH];
    end else if (acc_q[ACC_W-1]) begin
      pos_sat = POS_MIN;
    end else begin
      pos_sat = POS_MAX;
    end
  end

  assign trq_res  = prod[VEL_W+FRAC_SH-1:FRAC_SH];
  assign load_out = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    acc_d   = acc_q;
    vel_d   = vel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && id_match) begin
          state_d = S_TURN;
        end
      end
      S_TURN:  state_d = S_COUNT;
      S_COUNT: begin
        // raw position plus whole turns
        count_d = COUNT_W'(raw_pos_q) + COUNT_W'(prod);
        state_d = S_LO;
      end
      S_LO: begin
        vel_d   = prod[VEL_W+FRAC_SH-1:FRAC_SH];
        state_d = S_HI;
      end
      S_HI: begin
        // low partial product is unsigned
        acc_d   = signed'(ACC_W'(prod[LO_W+31:0]));
        state_d = S_TRQ;
      end
      S_TRQ: begin
        acc_d   = acc_q + (ACC_W'(prod) <<< LO_W);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {rotor_q, stage_q, byte0_q[3:0], byte0_q[7:4],
                     trq_res, vel_q, pos_sat};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      turn_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      turn_q      <= turn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && id_match) begin
      raw_pos_q <= signed'(pos_bits);
      raw_vel_q <= signed'({s_axis_tdata[31:24], s_axis_tdata[39:36]});
      raw_trq_q <= signed'({s_axis_tdata[35:32], s_axis_tdata[47:40]});
      byte0_q   <= s_axis_tdata[7:0];
      stage_q   <= s_axis_tdata[55:48];
      rotor_q   <= s_axis_tdata[63:56];
    end
    count_q    <= count_d;
    acc_q      <= acc_d;
    vel_q      <= vel_d;
    out_data_q <= out_data_d;
  end

  // turn state moves only on a matching frame
  a_turn_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && id_match) |=> $stable(turn_q) && $stable(last_q))
    else $error("turn state changed without a matching frame");

  // a matching frame starts the multiply sequence
  a_seq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && id_match |=> state_q == S_TURN)
    else $error("sequence did not start on a matching frame");

  // a mismatching frame leaves the block ready
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !id_match |=> s_axis_tready && !$rose(m_axis_tvalid))
    else $error("mismatching frame was not dropped");

  // finishing the sequence always presents a result
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid && state_q == S_IDLE)
    else $error("result not presented after sequence end");

endmodule

FILE: sv/mfud_cfg.sv
module mfud_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mfud_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mfud_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mfud_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output mfud_pkg::cfg_t                  cfg_o
);
  import mfud_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FEEDBACK_ID:    cfg_d.feedback_id      = pwdata[10:0];
        REG_HALF_TURN:      cfg_d.half_turn_counts = pwdata[14:0];
        REG_POSITION_SCALE: cfg_d.position_scale   = pwdata;
        REG_VELOCITY_SCALE: cfg_d.velocity_scale   = pwdata;
        REG_TORQUE_SCALE:   cfg_d.torque_scale     = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FEEDBACK_ID:    prdata = APB_DATA_W'(cfg_q.feedback_id);
      REG_HALF_TURN:      prdata = APB_DATA_W'(cfg_q.half_turn_counts);
      REG_POSITION_SCALE: prdata = cfg_q.position_scale;
      REG_VELOCITY_SCALE: prdata = cfg_q.velocity_scale;
      REG_TORQUE_SCALE:   prdata = cfg_q.torque_scale;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.feedback_id      <= RST_FEEDBACK_ID;
      cfg_q.half_turn_counts <= RST_HALF_TURN;
      cfg_q.position_scale   <= RST_POSITION_SCALE;
      cfg_q.velocity_scale   <= RST_VELOCITY_SCALE;
      cfg_q.torque_scale     <= RST_TORQUE_SCALE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: sv/mfud_mul.sv
module mfud_mul (
  input  logic                                clk_i,
  input  logic signed [mfud_pkg::MUL_W-1:0]   op_a_i,
  input  logic signed [mfud_pkg::MUL_W-1:0]   op_b_i,
  output logic signed [mfud_pkg::PROD_W-1:0]  prod_o
);
  import mfud_pkg::*;

  logic signed [PROD_W-1:0] prod_q, prod_d;

  // registered signed product
  assign prod_d = PROD_W'(op_a_i) * PROD_W'(op_b_i);
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

endmodule

FILE: tb/sv/tb_motor_feedback_unwrap_decoder.sv
`timescale 1ns / 100ps

module tb_motor_feedback_unwrap_decoder;
  import mfud_pkg::*;

  localparam int unsigned TURN_W     = 24;
  // cycles to let a frame without a result clear the block before a register write
  localparam int unsigned SETTLE_CYC = 16;
  // index past the register list, writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;

  // one decoded result, laid out as on m_axis_tdata (msb first)
  typedef struct packed {
    logic [7:0]         rotor_temp;
    logic [7:0]         stage_temp;
    logic [3:0]         motor_index;
    logic [3:0]         fault_code;
    logic signed [31:0] torque_q16;
    logic signed [31:0] velocity_q16;
    logic signed [47:0] position_q16;
  } feedback_t;

  // one received frame waiting to be offered
  typedef struct packed {
    logic [10:0] frame_id;
    logic [63:0] payload;
  } frame_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata  = '0;
  logic [10:0]           s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [135:0]          m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  motor_feedback_unwrap_decoder #(
    .TURN_BITS(TURN_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 4 ns period
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // shadow of the register file, kept in step with every write
  logic [10:0] cfg_fid    = RST_FEEDBACK_ID;
  logic [14:0] cfg_half   = RST_HALF_TURN;
  logic [31:0] cfg_pscale = RST_POSITION_SCALE;
  logic [31:0] cfg_vscale = RST_VELOCITY_SCALE;
  logic [31:0] cfg_tscale = RST_TORQUE_SCALE;

  // shadow of the multi-turn state
  logic [15:0]       mdl_last_pos = '0;
  logic [TURN_W-1:0] mdl_turns    = '0;

  frame_t    frame_q[$];     // frames still to be offered
  feedback_t want_fb_q[$];   // decoded results still owed by the block

  bit          idle_on     = 1'b1;
  bit          frame_taken = 1'b0;
  int unsigned send_gap    = 0;
  int unsigned recv_gap    = 0;
  int unsigned err_cnt     = 0;
  logic [15:0] gen_pos     = '0;

  // decode one accepted frame and queue the result it should give
  function automatic void decode_frame(input logic [10:0] fid, input logic [63:0] pl);
    logic [15:0]         pos_bits;
    logic signed [15:0]  delta;
    logic signed [11:0]  vel_raw;
    logic signed [11:0]  trq_raw;
    longint              half;
    longint              cnt;
    longint              vel_p;
    longint              trq_p;
    logic signed [127:0] cnt_w;
    logic signed [127:0] scl_w;
    logic signed [127:0] prod;
    feedback_t           r;
    // frames for another node leave the state alone
    if (fid != cfg_fid) return;
    pos_bits = {pl[15:8], pl[23:16]};
    vel_raw  = {pl[31:24], pl[39:36]};
    trq_raw  = {pl[35:32], pl[47:40]};
    // wrapped delta against the half-turn threshold, exactly half does not step
    delta = pos_bits - mdl_last_pos;
    half  = longint'(cfg_half);
    if (delta > half) mdl_turns = mdl_turns - 1'b1;
    else if (delta < -half) mdl_turns = mdl_turns + 1'b1;
    mdl_last_pos = pos_bits;
    cnt = longint'($signed(pos_bits)) + longint'($signed(mdl_turns)) * 2 * half;
    // product can pass 64 bits, so widen before scaling; >>> gives the floor
    cnt_w = cnt;
    scl_w = {96'd0, cfg_pscale};
    prod  = (cnt_w * scl_w) >>> FRAC_SH;
    if (prod > $signed(POS_MAX)) r.position_q16 = POS_MAX;
    else if (prod < $signed(POS_MIN)) r.position_q16 = POS_MIN;
    else r.position_q16 = prod[47:0];
    vel_p = (longint'(vel_raw) * longint'(cfg_vscale)) >>> FRAC_SH;
    trq_p = (longint'(trq_raw) * longint'(cfg_tscale)) >>> FRAC_SH;
    r.velocity_q16 = vel_p[31:0];
    r.torque_q16   = trq_p[31:0];
    r.fault_code   = pl[7:4];
    r.motor_index  = pl[3:0];
    r.stage_temp   = pl[55:48];
    r.rotor_temp   = pl[63:56];
    want_fb_q.push_back(r);
  endfunction

  // assemble the 8 payload bytes from the frame fields
  function automatic logic [63:0] pack_payload(input logic [15:0] pos, input logic [11:0] vel,
                                               input logic [11:0] trq, input logic [7:0] b0,
                                               input logic [7:0] stage, input logic [7:0] rotor);
    return {rotor, stage, trq[7:0], vel[3:0], trq[11:8], vel[11:4], pos[7:0], pos[15:8], b0};
  endfunction

  // frame source: a request stays up until taken, then a random gap may follow
  always @(negedge clk_i) begin : source
    frame_t cur;
    if (rst_ni && (!s_axis_tvalid || frame_taken)) begin
      frame_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (frame_q.size() > 0) begin
        cur = frame_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur.payload;
        s_axis_tuser  <= cur.frame_id;
        if (idle_on && $urandom_range(3) == 0) send_gap = $urandom_range(8, 1);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink: back-pressure in random bursts
  always @(negedge clk_i) begin : sink
    if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(4) == 0) begin
      recv_gap = $urandom_range(7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // both handshakes sampled on the rising edge; results checked before new
  // frames are decoded so the queue order never depends on process order
  always @(posedge clk_i) begin : scoreboard
    feedback_t got;
    feedback_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (want_fb_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("result with nothing pending: %h", got);
        end else begin
          want = want_fb_q.pop_front();
          if (got.position_q16 !== want.position_q16 || got.velocity_q16 !== want.velocity_q16 ||
              got.torque_q16 !== want.torque_q16 || got.fault_code !== want.fault_code ||
              got.motor_index !== want.motor_index || got.stage_temp !== want.stage_temp ||
              got.rotor_temp !== want.rotor_temp) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch pos exp %0d got %0d, vel exp %0d got %0d, trq exp %0d got %0d",
                       want.position_q16, got.position_q16, want.velocity_q16,
                       got.velocity_q16, want.torque_q16, got.torque_q16);
              $display("  fault %h/%h index %h/%h stage %h/%h rotor %h/%h (exp/got)",
                       want.fault_code, got.fault_code, want.motor_index, got.motor_index,
                       want.stage_temp, got.stage_temp, want.rotor_temp, got.rotor_temp);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_frame(s_axis_tuser, s_axis_tdata);
        frame_taken = 1'b1;
      end
    end
  end

  // apb write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FEEDBACK_ID:    cfg_fid    = val[10:0];
      REG_HALF_TURN:      cfg_half   = val[14:0];
      REG_POSITION_SCALE: cfg_pscale = val;
      REG_VELOCITY_SCALE: cfg_vscale = val;
      REG_TORQUE_SCALE:   cfg_tscale = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [10:0] fid, input logic [14:0] half,
                            input logic [31:0] ps, input logic [31:0] vs, input logic [31:0] ts);
    reg_write(REG_FEEDBACK_ID, {21'd0, fid});
    reg_write(REG_HALF_TURN, {17'd0, half});
    reg_write(REG_POSITION_SCALE, ps);
    reg_write(REG_VELOCITY_SCALE, vs);
    reg_write(REG_TORQUE_SCALE, ts);
  endtask

  // hold until every frame is taken and every result is back, then let it settle
  task automatic wait_drained();
    do @(posedge clk_i); while (frame_q.size() != 0 || s_axis_tvalid || want_fb_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // mostly well-formed motion: small steps, steps around the wrap threshold,
  // big jumps and standstill; a fifth of frames carry a random identifier
  task automatic add_random_frames(input int n);
    int unsigned hh;
    int unsigned mode;
    logic [15:0] step;
    logic [10:0] id;
    for (int i = 0; i < n; i++) begin
      hh   = (cfg_half < 64) ? 64 : cfg_half;
      mode = $urandom_range(9);
      if (mode < 5) begin
        step = 16'($urandom_range(2 * hh) - hh);
      end else if (mode < 7) begin
        step = 16'(cfg_half + $urandom_range(2) - 1);
        if ($urandom_range(1) == 1) step = -step;
      end else if (mode < 9) begin
        step = 16'($urandom);
      end else begin
        step = '0;
      end
      gen_pos = gen_pos + step;
      id = ($urandom_range(4) == 0) ? 11'($urandom) : cfg_fid;
      frame_q.push_back('{frame_id: id,
                          payload: pack_payload(gen_pos, 12'($urandom), 12'($urandom),
                                                8'($urandom), 8'($urandom), 8'($urandom))});
    end
  endtask

  // fixed stride per frame, used to drive the turn counter far in one direction
  task automatic add_sweep(input int n, input logic [15:0] stride);
    for (int i = 0; i < n; i++) begin
      gen_pos = gen_pos + stride;
      frame_q.push_back('{frame_id: cfg_fid,
                          payload: pack_payload(gen_pos, 12'($urandom), 12'($urandom),
                                                8'($urandom), 8'($urandom), 8'($urandom))});
    end
  endtask

  initial begin : stimulus
    // walk around the half-turn threshold from zero: full-scale jump, exactly
    // half, one past half in both directions
    logic [15:0] walk [9];
    walk = '{16'h0000, 16'h4000, 16'h8001, 16'h4001, 16'h0000,
             16'hC000, 16'h3FFF, 16'h3FFF, 16'h8000};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames on the reset settings
    frame_q.push_back('{frame_id: 11'd0, payload: 64'd0});
    frame_q.push_back('{frame_id: 11'd0, payload: {64{1'b1}}});
    // frames for other identifiers give nothing
    frame_q.push_back('{frame_id: 11'h7FF, payload: {64{1'b1}}});
    frame_q.push_back('{frame_id: 11'h001, payload: 64'd0});
    // extremes of velocity, torque, nibbles and temperatures
    frame_q.push_back('{frame_id: 11'd0,
                        payload: pack_payload(16'h7FFF, 12'h7FF, 12'h7FF, 8'h0F, 8'hFF, 8'h00)});
    frame_q.push_back('{frame_id: 11'd0,
                        payload: pack_payload(16'h8000, 12'h800, 12'h800, 8'hF0, 8'h00, 8'hFF)});
    for (int i = 0; i < 9; i++) begin
      frame_q.push_back('{frame_id: 11'd0,
                          payload: pack_payload(walk[i], 12'($urandom), 12'($urandom),
                                                8'($urandom), 8'($urandom), 8'($urandom))});
    end
    frame_q.push_back('{frame_id: 11'd0,
                        payload: pack_payload(16'h8000, 12'h001, 12'hFFF, 8'hA5, 8'h5A, 8'hC3)});
    wait_drained();

    // random phases, each cut in two by a full drain so the sender pauses
    for (int c = 0; c < 4; c++) begin
      case (c)
        0: set_config(11'h7FF, 15'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: set_config(11'h000, 15'd32767, 32'd0, 32'd0, 32'd0);
        // zero threshold: any nonzero delta steps the counter
        2: set_config(11'($urandom), 15'd0, $urandom, $urandom, $urandom);
        default: begin
          // write past the register list, must be ignored
          reg_write(REG_SPARE, $urandom);
          set_config(11'($urandom), 15'($urandom_range(32767, 1)), $urandom_range(1 << 20),
                     $urandom, $urandom);
        end
      endcase
      add_random_frames(75);
      wait_drained();
      add_random_frames(75);
      wait_drained();
    end

    // last part without idling: one turn up per frame at the widest
    // threshold, then one turn down per frame on a narrower one
    idle_on = 1'b0;
    set_config(cfg_fid, 15'd32767, 32'hFFFF_FFFF, $urandom, $urandom);
    add_sweep(90, 16'h8000);
    wait_drained();
    reg_write(REG_HALF_TURN, 32'd30000);
    add_sweep(90, 16'd32000);
    wait_drained();

    if (err_cnt == 0 && want_fb_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
